[hw/rtl/hbto_pkg.sv]
// Shared types, codes and constants of the heartbeat timeout output gate.
package hbto_pkg;

   localparam int CHAN_MAX     = 4;
   localparam int CHANNELS_DEF = 4;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_AW       = 5;
   localparam int CSR_DW       = 32;
   localparam int REG_IDX_W    = 3;

   localparam logic [1:0] CMD_BEAT   = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_ENABLE = 2'd2;

   localparam logic [1:0] KIND_NOP    = 2'd0;
   localparam logic [1:0] KIND_BEAT   = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_ENABLE = 2'd3;

   localparam logic [1:0] CH_STARTING = 2'd0;
   localparam logic [1:0] CH_ONLINE   = 2'd1;
   localparam logic [1:0] CH_OFFLINE  = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_REQUIRED = 3'd5;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  channel;
      logic [31:0] now_ms;
      logic        enable;
   } item_type;

   typedef struct packed {
      logic [CHAN_MAX-1:0][15:0] timeout;
      logic [CHAN_MAX-1:0]       active;
      logic [CHAN_MAX-1:0]       required;
   } cfg_type;

   typedef struct packed {
      logic                motor_allowed;
      logic                motor_enabled;
      logic [CHAN_MAX-1:0] online_mask;
      logic [CHAN_MAX-1:0] offline_mask;
      logic [CHAN_MAX-1:0] went_online;
      logic [CHAN_MAX-1:0] went_offline;
      logic [31:0]         elapsed_ms;
      logic                watchdog_kick;
   } result_type;

endpackage

[hw/rtl/heartbeat_timeout_output_gate_unit.sv]
// Top level of the heartbeat timeout output gate: CSR block, front end and back end.
//
// Usage
//   Input words enter on the req_ channel (push/full). cmd 0 stamps a heartbeat on
//   a channel, cmd 1 is the periodic tick that checks every active channel, cmd 2
//   writes the output enable latch; cmd 3 changes nothing. Every word yields one
//   result word on the rsp_ channel (empty/pop) with the gate status after it.
//   Timeouts and the active and required masks sit in CSRs on the APB-style csr_
//   port, one register every 4 bytes; write them only while the block is idle.
// Flow
//   A two-word front queue takes input while the back end works; the back end takes a
//   word from it while idle. Heartbeat, enable and no-op words load the result as they
//   are taken, one word per cycle while the result slot is free. A tick holds the back
//   end through its steps (take it, visit one channel per cycle through the single
//   subtract-and-compare unit, form the status), and its result loads at the last step.
// Reset and stall
//   Synchronous reset sets every channel to starting, drops enable and allowed, empties
//   both queues and loads the CSR reset values. While the receiver holds off pop, the
//   result register holds, the back end waits, and req_full rises once the queue fills.
module heartbeat_timeout_output_gate_unit #(
   parameter int CHANNELS = hbto_pkg::CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_cmd,
   input  logic [1:0]                    req_channel,
   input  logic [31:0]                   req_now_ms,
   input  logic                          req_enable,
   // result channel
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_motor_allowed,
   output logic                          rsp_motor_enabled,
   output logic [3:0]                    rsp_online_mask,
   output logic [3:0]                    rsp_offline_mask,
   output logic [3:0]                    rsp_went_online,
   output logic [3:0]                    rsp_went_offline,
   output logic [31:0]                   rsp_elapsed_ms,
   output logic                          rsp_watchdog_kick,
   // CSR port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hbto_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hbto_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hbto_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   logic [15:0]                    timeout_ff [hbto_pkg::CHAN_MAX];
   logic [hbto_pkg::CHAN_MAX-1:0]  active_ff;
   logic [hbto_pkg::CHAN_MAX-1:0]  required_ff;
   logic [hbto_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           csr_wr;
   hbto_pkg::cfg_type              cfg;
   logic                           item_valid;
   logic                           item_take;
   hbto_pkg::item_type             item;
   hbto_pkg::result_type           rsp;

   // CSR access: no wait states, registers every 4 bytes.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[hbto_pkg::CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hbto_pkg::CHAN_MAX; i++) begin
            timeout_ff[i] <= hbto_pkg::TIMEOUT_RESET;
         end
         active_ff   <= '0;
         required_ff <= '0;
      end else if (csr_wr) begin
         // Drop writes to addresses past the register list.
         unique case (reg_idx)
            hbto_pkg::REG_TIMEOUT0: timeout_ff[0] <= csr_pwdata[15:0];
            hbto_pkg::REG_TIMEOUT1: timeout_ff[1] <= csr_pwdata[15:0];
            hbto_pkg::REG_TIMEOUT2: timeout_ff[2] <= csr_pwdata[15:0];
            hbto_pkg::REG_TIMEOUT3: timeout_ff[3] <= csr_pwdata[15:0];
            hbto_pkg::REG_ACTIVE:   active_ff     <= csr_pwdata[hbto_pkg::CHAN_MAX-1:0];
            hbto_pkg::REG_REQUIRED: required_ff   <= csr_pwdata[hbto_pkg::CHAN_MAX-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         hbto_pkg::REG_TIMEOUT0: csr_prdata = {16'd0, timeout_ff[0]};
         hbto_pkg::REG_TIMEOUT1: csr_prdata = {16'd0, timeout_ff[1]};
         hbto_pkg::REG_TIMEOUT2: csr_prdata = {16'd0, timeout_ff[2]};
         hbto_pkg::REG_TIMEOUT3: csr_prdata = {16'd0, timeout_ff[3]};
         hbto_pkg::REG_ACTIVE:   csr_prdata = {28'd0, active_ff};
         hbto_pkg::REG_REQUIRED: csr_prdata = {28'd0, required_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // Bundle the configuration for the back end.
   always_comb begin
      for (int i = 0; i < hbto_pkg::CHAN_MAX; i++) begin
         cfg.timeout[i] = timeout_ff[i];
      end
      cfg.active   = active_ff;
      cfg.required = required_ff;
   end

   // Front end: classify and queue input words.
   hbto_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_cmd     (req_cmd),
      .req_channel (req_channel),
      .req_now_ms  (req_now_ms),
      .req_enable  (req_enable),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take)
   );

   // Back end: carry out heartbeats, ticks and enable writes; hold the result.
   hbto_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp)
   );

   // Fan the result word out onto its ports.
   assign rsp_motor_allowed  = rsp.motor_allowed;
   assign rsp_motor_enabled  = rsp.motor_enabled;
   assign rsp_online_mask    = rsp.online_mask;
   assign rsp_offline_mask   = rsp.offline_mask;
   assign rsp_went_online    = rsp.went_online;
   assign rsp_went_offline   = rsp.went_offline;
   assign rsp_elapsed_ms     = rsp.elapsed_ms;
   assign rsp_watchdog_kick  = rsp.watchdog_kick;

endmodule

[hw/rtl/hbto_front.sv]
// Front end: accept input words, classify the command, queue them for the back end.
module hbto_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_cmd,
   input  logic [1:0]           req_channel,
   input  logic [31:0]          req_now_ms,
   input  logic                 req_enable,
   output logic                 item_valid,
   output hbto_pkg::item_type   item,
   input  logic                 item_take
);

   hbto_pkg::item_type                queue_ff [hbto_pkg::QUEUE_DEPTH];
   logic [hbto_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hbto_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hbto_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              push_ok;
   hbto_pkg::item_type                new_item;

   // Classify the command; the unused code becomes a no-op word.
   always_comb begin
      new_item.channel = req_channel;
      new_item.now_ms  = req_now_ms;
      new_item.enable  = req_enable;
      unique case (req_cmd)
         hbto_pkg::CMD_BEAT:   new_item.kind = hbto_pkg::KIND_BEAT;
         hbto_pkg::CMD_TICK:   new_item.kind = hbto_pkg::KIND_TICK;
         hbto_pkg::CMD_ENABLE: new_item.kind = hbto_pkg::KIND_ENABLE;
         default:              new_item.kind = hbto_pkg::KIND_NOP;
      endcase
   end

   assign req_full   = (count_ff == hbto_pkg::QCNT_W'(hbto_pkg::QUEUE_DEPTH));
   assign push_ok    = req_push && !req_full;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   // Depth is a power of two, so the pointers wrap on their own.
   always_comb begin
      wr_ptr_in = push_ok   ? wr_ptr_ff + hbto_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = item_take ? rd_ptr_ff + hbto_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !item_take) begin
         count_in = count_ff + hbto_pkg::QCNT_W'(1);
      end else if (!push_ok && item_take) begin
         count_in = count_ff - hbto_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hbto_pkg::QCNT_W'(hbto_pkg::QUEUE_DEPTH))
      else $error("front queue count exceeds depth");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_take |-> item_valid)
      else $error("back end took a word from an empty front queue");

   a_full_has_word: assert property (@(posedge clock) disable iff (reset)
      req_full |-> item_valid)
      else $error("front queue reports full with no word waiting");
`endif

endmodule

[hw/rtl/hbto_back.sv]
// Back end: channel state, tick scan sequencer and the result register.
module hbto_back #(
   parameter int CHANNELS = hbto_pkg::CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hbto_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  hbto_pkg::item_type   item,
   output logic                 item_take,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output hbto_pkg::result_type rsp
);

   localparam int SCAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(CHANNELS - 1);
   localparam logic [hbto_pkg::CHAN_MAX-1:0] CH_MASK =
      hbto_pkg::CHAN_MAX'((1 << CHANNELS) - 1);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SCAN   = 2'd1;
   localparam logic [1:0] PH_FINISH = 2'd2;

   logic [31:0]                  last_ff [CHANNELS];
   logic [31:0]                  last_in [CHANNELS];
   logic [31:0]                  offt_ff [CHANNELS];
   logic [31:0]                  offt_in [CHANNELS];
   logic [1:0]                   cstate_ff [CHANNELS];
   logic [1:0]                   cstate_in [CHANNELS];
   logic [CHANNELS-1:0]          seen_ff, seen_in;
   logic                         enable_ff, enable_in;
   logic                         allowed_ff, allowed_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [SCAN_W-1:0]            scan_ff, scan_in;
   logic [31:0]                  tick_now_ff, tick_now_in;
   logic [1:0]                   tick_ch_ff, tick_ch_in;
   logic [hbto_pkg::CHAN_MAX-1:0] up_ff, up_in, down_ff, down_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   hbto_pkg::result_type         rsp_ff, rsp_in;

   logic [hbto_pkg::CHAN_MAX-1:0] act, req, onl, offl;
   logic                         slot_free, rsp_load, all_online;
   logic [31:0]                  sel_last, elapsed, res_el;
   logic [15:0]                  sel_to;
   logic [1:0]                   sel_state, res_ch;
   logic                         sel_seen, sel_active, in_time, res_tick;

   assign act       = cfg.active & CH_MASK;
   assign req       = cfg.required & act;
   assign slot_free = !rsp_valid_ff || rsp_pop;

   // Pick the channel under scan; one subtract and compare serves all channels.
   always_comb begin
      sel_last   = '0;
      sel_to     = '0;
      sel_state  = hbto_pkg::CH_STARTING;
      sel_seen   = 1'b0;
      sel_active = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (scan_ff == SCAN_W'(i)) begin
            sel_last   = last_ff[i];
            sel_to     = cfg.timeout[i];
            sel_state  = cstate_ff[i];
            sel_seen   = seen_ff[i];
            sel_active = act[i];
         end
      end
   end

   assign elapsed = tick_now_ff - sel_last;
   assign in_time = (elapsed <= {16'd0, sel_to});

   always_comb begin
      onl = '0;
      offl = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         onl[i]  = (cstate_ff[i] == hbto_pkg::CH_ONLINE);
         offl[i] = (cstate_ff[i] == hbto_pkg::CH_OFFLINE);
      end
   end

   assign all_online = (req != '0) && ((req & ~onl) == '0);

   always_comb begin
      last_in      = last_ff;
      offt_in      = offt_ff;
      cstate_in    = cstate_ff;
      seen_in      = seen_ff;
      enable_in    = enable_ff;
      allowed_in   = allowed_ff;
      phase_in     = phase_ff;
      scan_in      = scan_ff;
      tick_now_in  = tick_now_ff;
      tick_ch_in   = tick_ch_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      item_take    = 1'b0;
      rsp_load     = 1'b0;
      res_ch       = item.channel;
      res_tick     = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (item_valid) begin
               if (item.kind == hbto_pkg::KIND_TICK) begin
                  item_take   = 1'b1;
                  tick_now_in = item.now_ms;
                  tick_ch_in  = item.channel;
                  scan_in     = '0;
                  up_in       = '0;
                  down_in     = '0;
                  phase_in    = PH_SCAN;
               end else if (slot_free) begin
                  item_take = 1'b1;
                  rsp_load  = 1'b1;
                  if (item.kind == hbto_pkg::KIND_BEAT && act[item.channel]) begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        if (item.channel == 2'(i)) begin
                           last_in[i] = item.now_ms;
                           seen_in[i] = 1'b1;
                        end
                     end
                  end
                  if (item.kind == hbto_pkg::KIND_ENABLE) begin
                     enable_in = item.enable;
                     if (!item.enable) begin
                        allowed_in = 1'b0;
                     end
                  end
               end
            end
         end
         PH_SCAN: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (scan_ff == SCAN_W'(i) && sel_active) begin
                  offt_in[i] = elapsed;
                  if (sel_seen && in_time) begin
                     if (sel_state != hbto_pkg::CH_ONLINE) begin
                        cstate_in[i] = hbto_pkg::CH_ONLINE;
                        offt_in[i]   = '0;
                        up_in[i]     = 1'b1;
                     end
                  end else if (!in_time) begin
                     if (sel_state != hbto_pkg::CH_OFFLINE) begin
                        cstate_in[i] = hbto_pkg::CH_OFFLINE;
                        down_in[i]   = 1'b1;
                        if (cfg.required[i]) begin
                           enable_in  = 1'b0;
                           allowed_in = 1'b0;
                        end
                     end
                  end
               end
            end
            if (scan_ff == SCAN_LAST) begin
               phase_in = PH_FINISH;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         PH_FINISH: begin
            res_ch   = tick_ch_ff;
            res_tick = 1'b1;
            if (slot_free) begin
               rsp_load   = 1'b1;
               allowed_in = enable_ff && all_online;
               phase_in   = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      res_el = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (res_ch == 2'(i)) begin
            res_el = offt_ff[i];
         end
      end
   end

   always_comb begin
      rsp_in.motor_allowed  = allowed_in;
      rsp_in.motor_enabled  = enable_in;
      rsp_in.online_mask    = onl;
      rsp_in.offline_mask   = offl;
      rsp_in.went_online    = res_tick ? up_ff : '0;
      rsp_in.went_offline   = res_tick ? down_ff : '0;
      rsp_in.elapsed_ms     = res_el;
      rsp_in.watchdog_kick  = res_tick;
      rsp_valid_in          = rsp_load ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            last_ff[i]   <= '0;
            offt_ff[i]   <= '0;
            cstate_ff[i] <= hbto_pkg::CH_STARTING;
         end
         seen_ff      <= '0;
         enable_ff    <= 1'b0;
         allowed_ff   <= 1'b0;
         phase_ff     <= PH_IDLE;
         scan_ff      <= '0;
         up_ff        <= '0;
         down_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         offt_ff      <= offt_in;
         cstate_ff    <= cstate_in;
         seen_ff      <= seen_in;
         enable_ff    <= enable_in;
         allowed_ff   <= allowed_in;
         phase_ff     <= phase_in;
         scan_ff      <= scan_in;
         up_ff        <= up_in;
         down_ff      <= down_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_now_ff <= tick_now_in;
      tick_ch_ff  <= tick_ch_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef NO_ASSERTIONS
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SCAN |-> scan_ff <= SCAN_LAST)
      else $error("tick scan index ran past the last channel");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      item_take |-> phase_ff == PH_IDLE)
      else $error("word taken while a tick scan is in progress");

   a_edges_disjoint: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp.went_online & rsp.went_offline) == '0)
      else $error("channel reported going online and offline in one tick");

   a_allowed_needs_enable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp.motor_allowed |-> rsp.motor_enabled)
      else $error("output allowed without output enable");
`endif

endmodule

[bench/testbench.sv]
// Self-checking bench for the heartbeat timeout output gate: directed plan, then random phases.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hbto_pkg::*;

   // cmd code 3 has no meaning in the block; it must report status and change nothing
   localparam logic [1:0] CMD_NOP = 2'd3;

   // register slots past the end of the map; writes there must be dropped
   localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   localparam int unsigned LONG_HOLD    = 64;
   localparam int unsigned PHASE_WORDS  = 87;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned LIMIT_NS     = 1_000_000;

   // ------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_push    = 1'b0;
   logic                 req_full;
   logic [1:0]           req_cmd     = CMD_BEAT;
   logic [1:0]           req_channel = 2'd0;
   logic [31:0]          req_now_ms  = 32'd0;
   logic                 req_enable  = 1'b0;

   logic                 rsp_empty;
   logic                 rsp_pop     = 1'b0;
   logic                 rsp_motor_allowed;
   logic                 rsp_motor_enabled;
   logic [3:0]           rsp_online_mask;
   logic [3:0]           rsp_offline_mask;
   logic [3:0]           rsp_went_online;
   logic [3:0]           rsp_went_offline;
   logic [31:0]          rsp_elapsed_ms;
   logic                 rsp_watchdog_kick;

   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr   = '0;
   logic [CSR_DW-1:0]    csr_pwdata  = '0;
   logic [CSR_DW-1:0]    csr_prdata;
   logic                 csr_pready;

   heartbeat_timeout_output_gate_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_cmd            (req_cmd),
      .req_channel        (req_channel),
      .req_now_ms         (req_now_ms),
      .req_enable         (req_enable),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_motor_allowed  (rsp_motor_allowed),
      .rsp_motor_enabled  (rsp_motor_enabled),
      .rsp_online_mask    (rsp_online_mask),
      .rsp_offline_mask   (rsp_offline_mask),
      .rsp_went_online    (rsp_went_online),
      .rsp_went_offline   (rsp_went_offline),
      .rsp_elapsed_ms     (rsp_elapsed_ms),
      .rsp_watchdog_kick  (rsp_watchdog_kick),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // ------------------------------------------------------------------
   // Gate model: our own copy of the register file and channel state
   // ------------------------------------------------------------------
   logic [15:0] tmo      [CHAN_MAX];
   logic [3:0]  act_m;
   logic [3:0]  req_m;
   logic [31:0] stamp_ms [CHAN_MAX];
   logic        has_beat [CHAN_MAX];
   logic [1:0]  chan_st  [CHAN_MAX];
   logic [31:0] down_ms  [CHAN_MAX];
   logic        en_latch;
   logic        allow_flag;

   // status words still owed by the block, oldest first
   result_type  ledger[$];

   // an expectation typed into the plan overrides the model for that word
   bit          pending_typed = 1'b0;
   result_type  pending_want  = '0;

   int unsigned mismatches = 0;
   int unsigned got_count  = 0;
   int unsigned idle_pct   = 30;   // chance in percent of a gap before a word or pop
   bit          hold_request = 1'b0;

   typedef struct {
      bit                   is_csr;
      logic [REG_IDX_W-1:0] reg_idx;
      logic [31:0]          wdata;
      logic [1:0]           cmd;
      logic [1:0]           ch;
      logic [31:0]          now;
      logic                 en;
      bit                   typed;
      result_type           want;
   } plan_row_type;

   plan_row_type plan[$];

   // ------------------------------------------------------------------
   // Clock, run limit
   // ------------------------------------------------------------------
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("testbench: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------
   task automatic model_reset();
      for (int i = 0; i < CHAN_MAX; i++) begin
         tmo[i]      = TIMEOUT_RESET;
         stamp_ms[i] = '0;
         has_beat[i] = 1'b0;
         chan_st[i]  = CH_STARTING;
         down_ms[i]  = '0;
      end
      act_m      = '0;
      req_m      = '0;
      en_latch   = 1'b0;
      allow_flag = 1'b0;
   endtask

   // mirror a register write; out-of-map indexes fall through untouched
   task automatic model_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      case (idx)
         REG_TIMEOUT0, REG_TIMEOUT1, REG_TIMEOUT2, REG_TIMEOUT3: begin
            tmo[idx[1:0]] = value[15:0];
         end
         REG_ACTIVE:   act_m = value[3:0];
         REG_REQUIRED: req_m = value[3:0];
         default: ;
      endcase
   endtask

   // advance the gate by one input word and return the status it reports
   function automatic result_type gate_step(input logic [1:0] cmd, input logic [1:0] ch,
                                            input logic [31:0] now, input logic en);
      result_type r;
      logic [31:0] gap;
      logic [3:0]  need;
      logic        all_up;
      r = '0;
      case (cmd)
         CMD_BEAT: begin
            // a beat on an unmonitored channel is dropped
            if (act_m[ch]) begin
               stamp_ms[ch] = now;
               has_beat[ch] = 1'b1;
            end
         end
         CMD_TICK: begin
            for (int i = 0; i < CHAN_MAX; i++) begin
               if (!act_m[i]) continue;
               // elapsed time wraps modulo 2^32
               gap = now - stamp_ms[i];
               down_ms[i] = gap;
               if (has_beat[i] && gap <= {16'd0, tmo[i]}) begin
                  if (chan_st[i] != CH_ONLINE) begin
                     chan_st[i] = CH_ONLINE;
                     down_ms[i] = '0;
                     r.went_online[i] = 1'b1;
                  end
               end else if (gap > {16'd0, tmo[i]}) begin
                  if (chan_st[i] != CH_OFFLINE) begin
                     chan_st[i] = CH_OFFLINE;
                     // losing a required channel kills the enable as well
                     if (req_m[i]) begin
                        en_latch   = 1'b0;
                        allow_flag = 1'b0;
                     end
                     r.went_offline[i] = 1'b1;
                  end
               end
            end
            // required-but-inactive channels count for nothing
            need   = req_m & act_m;
            all_up = (need != '0);
            for (int i = 0; i < CHAN_MAX; i++) begin
               if (need[i] && chan_st[i] != CH_ONLINE) all_up = 1'b0;
            end
            allow_flag = en_latch && all_up;
            r.watchdog_kick = 1'b1;
         end
         CMD_ENABLE: begin
            // enabling waits for the next tick, disabling bites at once
            en_latch = en;
            if (!en) allow_flag = 1'b0;
         end
         default: ;
      endcase
      for (int i = 0; i < CHAN_MAX; i++) begin
         r.online_mask[i]  = (chan_st[i] == CH_ONLINE);
         r.offline_mask[i] = (chan_st[i] == CH_OFFLINE);
      end
      r.elapsed_ms     = down_ms[ch];
      r.motor_allowed  = allow_flag;
      r.motor_enabled  = en_latch;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: compare popped words first, then book newly accepted ones
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result word %0d: %s expected %0h, got %0h", got_count, name, want, got);
      end
   endtask

   task automatic check_word();
      result_type want;
      if (ledger.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result word %0d arrived with nothing outstanding", got_count);
      end else begin
         want = ledger.pop_front();
         check_field("motor_allowed",  want.motor_allowed,  rsp_motor_allowed);
         check_field("motor_enabled",  want.motor_enabled,  rsp_motor_enabled);
         check_field("online_mask",    want.online_mask,    rsp_online_mask);
         check_field("offline_mask",   want.offline_mask,   rsp_offline_mask);
         check_field("went_online",    want.went_online,    rsp_went_online);
         check_field("went_offline",   want.went_offline,   rsp_went_offline);
         check_field("elapsed_ms",     want.elapsed_ms,     rsp_elapsed_ms);
         check_field("watchdog_kick",  want.watchdog_kick,  rsp_watchdog_kick);
      end
      got_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) check_word();
         if (req_push && !req_full) begin
            // run the model on every accepted word so state stays in step
            pending_want = pending_typed ? pending_want : '0;
            if (pending_typed)
               begin
                  void'(gate_step(req_cmd, req_channel, req_now_ms, req_enable));
                  ledger.push_back(pending_want);
               end
            else
               ledger.push_back(gate_step(req_cmd, req_channel, req_now_ms, req_enable));
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: pop with random gaps; honor a long hold-off on request
   // ------------------------------------------------------------------
   function automatic int unsigned gap_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         // count the long hold-off here, cycle by cycle
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct) stall_left = gap_len();
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender and register port
   // ------------------------------------------------------------------
   // offer one word, optionally after a gap, and hold it until it is taken
   task automatic send_word(input logic [1:0] cmd, input logic [1:0] ch,
                            input logic [31:0] now, input logic en,
                            input bit typed, input result_type want);
      int unsigned gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
      if (gap != 0) begin
         @(negedge clock) req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push      <= 1'b1;
      req_cmd       <= cmd;
      req_channel   <= ch;
      req_now_ms    <= now;
      req_enable    <= en;
      pending_typed = typed;
      pending_want  = want;
      do @(posedge clock); while (req_full);
   endtask

   // drop push and let every owed status word come home before touching registers
   task automatic settle();
      @(negedge clock) req_push <= 1'b0;
      while (ledger.size() != 0) @(posedge clock);
      repeat (CHAN_MAX + 4) @(posedge clock);
   endtask

   // setup cycle, then access cycle; the write lands on the edge with pready high
   task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Directed plan
   // ------------------------------------------------------------------
   function automatic result_type gate_status(input logic allowed, input logic enabled,
                                              input logic [3:0] onl, input logic [3:0] offl,
                                              input logic [3:0] up, input logic [3:0] down,
                                              input logic [31:0] el, input logic kick);
      result_type r;
      r.motor_allowed  = allowed;
      r.motor_enabled  = enabled;
      r.online_mask    = onl;
      r.offline_mask   = offl;
      r.went_online    = up;
      r.went_offline   = down;
      r.elapsed_ms     = el;
      r.watchdog_kick  = kick;
      return r;
   endfunction

   function automatic plan_row_type word_row(input logic [1:0] cmd, input logic [1:0] ch,
                                             input logic [31:0] now, input logic en);
      plan_row_type p;
      p = '{is_csr: 1'b0, reg_idx: '0, wdata: '0, cmd: cmd, ch: ch, now: now, en: en,
            typed: 1'b0, want: '0};
      return p;
   endfunction

   function automatic plan_row_type known_row(input logic [1:0] cmd, input logic [1:0] ch,
                                              input logic [31:0] now, input logic en,
                                              input result_type want);
      plan_row_type p;
      p       = word_row(cmd, ch, now, en);
      p.typed = 1'b1;
      p.want  = want;
      return p;
   endfunction

   function automatic plan_row_type reg_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [31:0] v);
      plan_row_type p;
      p         = word_row(CMD_BEAT, 2'd0, 32'd0, 1'b0);
      p.is_csr  = 1'b1;
      p.reg_idx = idx;
      p.wdata   = v;
      return p;
   endfunction

   task automatic build_plan();
      // reset defaults: nothing monitored, so nothing can go online or be allowed
      plan.push_back(known_row(CMD_TICK,   2'd0, 32'h0,        1'b0,
                               gate_status(0, 0, 4'h0, 4'h0, 4'h0, 4'h0, 32'd0, 1)));
      plan.push_back(known_row(CMD_BEAT,   2'd3, 32'hFFFF_FFFF, 1'b1,
                               gate_status(0, 0, 4'h0, 4'h0, 4'h0, 4'h0, 32'd0, 0)));
      plan.push_back(known_row(CMD_NOP,    2'd2, 32'hFFFF_FFFF, 1'b1,
                               gate_status(0, 0, 4'h0, 4'h0, 4'h0, 4'h0, 32'd0, 0)));
      plan.push_back(known_row(CMD_ENABLE, 2'd1, 32'h0,        1'b1,
                               gate_status(0, 1, 4'h0, 4'h0, 4'h0, 4'h0, 32'd0, 0)));
      plan.push_back(known_row(CMD_TICK,   2'd3, 32'hFFFF_FFFF, 1'b0,
                               gate_status(0, 1, 4'h0, 4'h0, 4'h0, 4'h0, 32'd0, 1)));
      // timeouts at the extremes, all four monitored, ch0/ch1 required
      plan.push_back(reg_row(REG_TIMEOUT0, 32'h0));
      plan.push_back(reg_row(REG_TIMEOUT1, 32'h1));
      plan.push_back(reg_row(REG_TIMEOUT2, 32'hFFFF_FFFF));
      plan.push_back(reg_row(REG_TIMEOUT3, 32'd100));
      plan.push_back(reg_row(REG_ACTIVE,   32'hFFFF_FFFF));
      plan.push_back(reg_row(REG_REQUIRED, 32'h3));
      plan.push_back(reg_row(REG_UNUSED_LO, 32'hFFFF_FFFF));
      plan.push_back(reg_row(REG_UNUSED_HI, 32'h0));
      plan.push_back(word_row(CMD_BEAT,   2'd0, 32'd1000,      1'b0));
      plan.push_back(word_row(CMD_BEAT,   2'd1, 32'd1000,      1'b0));
      plan.push_back(word_row(CMD_BEAT,   2'd2, 32'hFFFF_FFF0, 1'b0));  // stamp before wrap
      plan.push_back(word_row(CMD_TICK,   2'd3, 32'd1000,      1'b0));  // ch3 never beat
      plan.push_back(word_row(CMD_ENABLE, 2'd0, 32'd7,         1'b1));
      plan.push_back(word_row(CMD_TICK,   2'd2, 32'd1000,      1'b0));
      plan.push_back(word_row(CMD_TICK,   2'd0, 32'd1001,      1'b0));  // zero timeout trips
      plan.push_back(word_row(CMD_ENABLE, 2'd1, 32'd0,         1'b1));
      plan.push_back(word_row(CMD_BEAT,   2'd0, 32'd1001,      1'b0));
      plan.push_back(word_row(CMD_TICK,   2'd0, 32'd1001,      1'b0));
      plan.push_back(word_row(CMD_ENABLE, 2'd1, 32'd0,         1'b0));  // disable drops allowed
      plan.push_back(word_row(CMD_TICK,   2'd2, 32'hFFFF_FFFF, 1'b0));
      // only inactive channels required
      plan.push_back(reg_row(REG_ACTIVE,   32'h5));
      plan.push_back(reg_row(REG_REQUIRED, 32'hA));
      plan.push_back(word_row(CMD_ENABLE, 2'd0, 32'd0,         1'b1));
      plan.push_back(word_row(CMD_BEAT,   2'd1, 32'd5,         1'b0));
      plan.push_back(word_row(CMD_TICK,   2'd1, 32'hFFFF_FFFF, 1'b0));
      // everything required, longest timeout
      plan.push_back(reg_row(REG_ACTIVE,   32'hF));
      plan.push_back(reg_row(REG_REQUIRED, 32'hF));
      plan.push_back(reg_row(REG_TIMEOUT0, 32'hFFFF));
      plan.push_back(reg_row(REG_TIMEOUT1, 32'hFFFF));
      plan.push_back(reg_row(REG_TIMEOUT3, 32'hFFFF));
      for (int i = 0; i < CHAN_MAX; i++)
         plan.push_back(word_row(CMD_BEAT, i[1:0], 32'd0, 1'b0));
      plan.push_back(word_row(CMD_ENABLE, 2'd2, 32'd0,         1'b1));
      plan.push_back(word_row(CMD_TICK,   2'd0, 32'd65535,     1'b0));  // right at the limit
      plan.push_back(word_row(CMD_TICK,   2'd3, 32'd65536,     1'b0));  // one past it
   endtask

   // ------------------------------------------------------------------
   // Random stimulus
   // ------------------------------------------------------------------
   logic [31:0] wall_ms;

   function automatic logic [15:0] pick_timeout();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 20) return 16'hFFFF;
      if (r < 30) return 16'd1;
      return 16'($urandom_range(2, 40));
   endfunction

   // mostly a plausible stream (beats at the current time, ticks moving forward),
   // the rest arbitrary noise
   task automatic random_word(output logic [1:0] cmd, output logic [1:0] ch,
                              output logic [31:0] now, output logic en);
      int unsigned r;
      int unsigned advance_ms;
      cmd = CMD_NOP;
      ch  = 2'($urandom_range(0, 3));
      now = $urandom;
      en  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 15) begin
         cmd = 2'($urandom_range(0, 3));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            cmd = CMD_BEAT;
            if (act_m != '0 && $urandom_range(0, 99) < 85)
               while (!act_m[ch]) ch = 2'($urandom_range(0, 3));
            now = wall_ms;
         end else if (r < 80) begin
            r = $urandom_range(0, 99);
            if (r < 60)      advance_ms = $urandom_range(0, 20);
            else if (r < 90) advance_ms = $urandom_range(0, 120);
            else             advance_ms = $urandom;
            wall_ms = wall_ms + advance_ms;
            cmd = CMD_TICK;
            now = wall_ms;
         end else begin
            cmd = CMD_ENABLE;
            en  = ($urandom_range(0, 99) < 70);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [1:0]  cmd;
      logic [1:0]  ch;
      logic [31:0] now;
      logic        en;
      int unsigned phase_words;

      model_reset();
      build_plan();
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // walk the directed plan
      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            settle();
            reg_write(plan[k].reg_idx, plan[k].wdata);
         end else begin
            send_word(plan[k].cmd, plan[k].ch, plan[k].now, plan[k].en,
                      plan[k].typed, plan[k].want);
         end
      end

      // random phases, each under a fresh register setting
      for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
         settle();
         for (int i = 0; i < CHAN_MAX; i++)
            reg_write(REG_TIMEOUT0 + i[REG_IDX_W-1:0],
                      {16'($urandom_range(0, 65535)), pick_timeout()});
         if (phase_no == RANDOM_PHASES - 1) begin
            reg_write(REG_ACTIVE,   32'hF);
            reg_write(REG_REQUIRED, 32'hF);
         end else begin
            reg_write(REG_ACTIVE,   $urandom_range(1, 15));
            reg_write(REG_REQUIRED, $urandom_range(0, 15));
         end
         // start near the 32-bit wrap now and then
         wall_ms = ($urandom_range(0, 99) < 30) ? 32'hFFFF_FFFF - $urandom_range(0, 200)
                                                : $urandom;
         // phase 2 backs the receiver up hard; phase 4 runs with no idling at all
         idle_pct = (phase_no == 2 || phase_no == 4) ? 0 : 30;
         if (phase_no == 2) begin
            @(posedge clock);
            hold_request = 1'b1;
         end
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            random_word(cmd, ch, now, en);
            phase_words++;
            send_word(cmd, ch, now, en, 1'b0, '0);
         end
      end

      // drain with a bound, then give the back end time for stray words
      @(negedge clock) req_push <= 1'b0;
      for (int k = 0; k < 4000 && ledger.size() != 0; k++) @(posedge clock);
      repeat (CHAN_MAX + 8) @(posedge clock);
      if (ledger.size() != 0) begin
         $display("%0d result words never arrived", ledger.size());
         mismatches += ledger.size();
      end
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
